### rtl/wlan_bssid_frame_filter_counter_assert.svh
// Assertion macros shared by the BSSID frame filter modules.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef WLAN_BSSID_FRAME_FILTER_COUNTER_ASSERT_SVH
`define WLAN_BSSID_FRAME_FILTER_COUNTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WBFFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WBFFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/wbffc_pkg.sv
// Shared types and constants for the BSSID frame filter and counter.
// No dependencies; every other file of the block except the assertion macro header refers to this package.
package wbffc_pkg;

    // Address and field geometry.
    localparam int ADDR_BYTES = 6;
    localparam int ADDR_W     = ADDR_BYTES * 8;
    localparam int FC_W       = 8;
    localparam int TYPE_LSB   = 2;
    localparam int TYPE_W     = 2;
    localparam int RSSI_W     = 8;
    localparam int TIME_W     = 32;

    // Beacon frames carry this exact first frame-control byte.
    localparam logic [FC_W-1:0] BEACON_BYTE = 8'h80;

    // Counter storage width and the width shown on the outputs.
    localparam int COUNT_WIDTH = 32;
    localparam int CNT_OUT_W   = 32;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // Queue between the classify stage and the update stage.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration port geometry: 64-bit registers on 8-byte spacing.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BSSID = CFG_IDX_W'(0);

    // Frame type decoded from frame-control bits 3:2.
    typedef enum logic [TYPE_W-1:0] {
        FC_MGMT = 2'd0,
        FC_CTRL = 2'd1,
        FC_DATA = 2'd2,
        FC_RSVD = 2'd3
    } t_frame_class;

    // One classified frame as it travels from front to back.
    typedef struct packed {
        t_frame_class              frame_class;
        logic                      mgmt_hit;
        logic                      any_hit;
        logic                      beacon_hit;
        logic signed [RSSI_W-1:0]  rssi;
        logic [TIME_W-1:0]         now_ms;
    } t_item;

    // Queue occupancy seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/wlan_bssid_frame_filter_counter.sv
// Top level of the BSSID frame filter and counter: register port, front
// stage, queue and back stage. Depends on wbffc_pkg, wbffc_front/queue/back.
//
//   Channel   Direction  Handshake               Payload
//   in        input      i_in_valid/o_in_stall   frame control, 3 addresses, rssi, time
//   out       output     o_out_valid/i_out_stall match, class, counters, beacon latch
//   cfg       input      psel/penable/pwrite     target_bssid at byte address 0
//
// One frame per cycle is sustained while the output is not stalled; after the front
// register accepts a frame, its result passes through a queue write and the result register.
// While the output is stalled, the front register and the two-entry queue hold
// up to three more frames; the input stalls once they are full.
// Synchronous active-low reset clears counters, the beacon latch, target BSSID
// and all valid flags; it needs no clearing pass.
module wlan_bssid_frame_filter_counter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wbffc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wbffc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wbffc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready,
    // Frame input.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [wbffc_pkg::FC_W-1:0]           i_frame_ctrl_byte,
    input  logic [wbffc_pkg::ADDR_W-1:0]         i_addr_one,
    input  logic [wbffc_pkg::ADDR_W-1:0]         i_addr_two,
    input  logic [wbffc_pkg::ADDR_W-1:0]         i_addr_three,
    input  logic signed [wbffc_pkg::RSSI_W-1:0]  i_rx_rssi,
    input  logic [wbffc_pkg::TIME_W-1:0]         i_now_ms,
    // Result output.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_matched,
    output logic [wbffc_pkg::TYPE_W-1:0]         o_frame_class,
    output logic [wbffc_pkg::CNT_OUT_W-1:0]      o_mgmt_count,
    output logic [wbffc_pkg::CNT_OUT_W-1:0]      o_ctrl_count,
    output logic [wbffc_pkg::CNT_OUT_W-1:0]      o_data_count,
    output logic signed [wbffc_pkg::RSSI_W-1:0]  o_rssi_latest,
    output logic [wbffc_pkg::TIME_W-1:0]         o_rssi_time_ms,
    output logic                                 o_rssi_updated
);

    logic [wbffc_pkg::ADDR_W-1:0]    r_target_bssid;
    logic [wbffc_pkg::CFG_IDX_W-1:0] reg_index;
    logic                            cfg_write;
    logic                            push;
    logic                            pop;
    wbffc_pkg::t_item                front_item;
    wbffc_pkg::t_item                queue_item;
    wbffc_pkg::t_q_status            q_status;

    // Register decode: one 64-bit register per 8-byte slot.
    assign pready    = 1'b1;
    assign reg_index = paddr[wbffc_pkg::CFG_ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_bssid <= '0;
        end else if (cfg_write && (reg_index == wbffc_pkg::REG_TARGET_BSSID)) begin
            r_target_bssid <= pwdata[wbffc_pkg::ADDR_W-1:0];
        end
    end

    // Read data for the register port.
    always_comb begin
        if (reg_index == wbffc_pkg::REG_TARGET_BSSID) begin
            prdata = wbffc_pkg::CFG_DATA_W'(r_target_bssid);
        end else begin
            prdata = '0;
        end
    end

    wbffc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_frame_ctrl_byte (i_frame_ctrl_byte),
        .i_addr_one        (i_addr_one),
        .i_addr_two        (i_addr_two),
        .i_addr_three      (i_addr_three),
        .i_rx_rssi         (i_rx_rssi),
        .i_now_ms          (i_now_ms),
        .i_target_bssid    (r_target_bssid),
        .i_q_status        (q_status),
        .o_push            (push),
        .o_item            (front_item)
    );

    wbffc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    wbffc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_matched      (o_matched),
        .o_frame_class  (o_frame_class),
        .o_mgmt_count   (o_mgmt_count),
        .o_ctrl_count   (o_ctrl_count),
        .o_data_count   (o_data_count),
        .o_rssi_latest  (o_rssi_latest),
        .o_rssi_time_ms (o_rssi_time_ms),
        .o_rssi_updated (o_rssi_updated)
    );

endmodule

### rtl/wbffc_front.sv
// Front stage: takes frame headers, compares addresses against the target
// BSSID and registers a classified item. Depends on wbffc_pkg.
module wbffc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [wbffc_pkg::FC_W-1:0]         i_frame_ctrl_byte,
    input  logic [wbffc_pkg::ADDR_W-1:0]       i_addr_one,
    input  logic [wbffc_pkg::ADDR_W-1:0]       i_addr_two,
    input  logic [wbffc_pkg::ADDR_W-1:0]       i_addr_three,
    input  logic signed [wbffc_pkg::RSSI_W-1:0] i_rx_rssi,
    input  logic [wbffc_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [wbffc_pkg::ADDR_W-1:0]       i_target_bssid,
    input  wbffc_pkg::t_q_status               i_q_status,
    output logic                               o_push,
    output wbffc_pkg::t_item                   o_item
);

    logic             r_valid;
    logic             n_valid;
    wbffc_pkg::t_item r_item;
    wbffc_pkg::t_item n_item;
    logic             accept;
    logic             hit_one;
    logic             hit_two;
    logic             hit_three;

    // The stage holds while its item cannot move into the queue.
    assign o_in_stall = r_valid && i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_item     = r_item;

    // Address compares and type decode.
    always_comb begin
        hit_one   = (i_addr_one == i_target_bssid);
        hit_two   = (i_addr_two == i_target_bssid);
        hit_three = (i_addr_three == i_target_bssid);
        n_item.frame_class = wbffc_pkg::t_frame_class'(
            i_frame_ctrl_byte[wbffc_pkg::TYPE_LSB +: wbffc_pkg::TYPE_W]);
        n_item.mgmt_hit   = hit_three;
        n_item.any_hit    = hit_one || hit_two || hit_three;
        n_item.beacon_hit = (i_frame_ctrl_byte == wbffc_pkg::BEACON_BYTE) && hit_two;
        n_item.rssi       = i_rx_rssi;
        n_item.now_ms     = i_now_ms;
    end

    // Stage occupancy.
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Item payload, loaded on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

### rtl/wbffc_queue.sv
// Short queue of classified frames between the front and back stages.
// Depends on wbffc_pkg and the shared assertion macros.
`include "wlan_bssid_frame_filter_counter_assert.svh"

module wbffc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wbffc_pkg::t_item      i_item,
    input  logic                  i_pop,
    output wbffc_pkg::t_item      o_item,
    output wbffc_pkg::t_q_status  o_status
);

    wbffc_pkg::t_item                 r_mem [wbffc_pkg::QUEUE_DEPTH];
    logic [wbffc_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [wbffc_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [wbffc_pkg::Q_CNT_W-1:0]    r_count;
    logic [wbffc_pkg::Q_PTR_W-1:0]    n_wr_ptr;
    logic [wbffc_pkg::Q_PTR_W-1:0]    n_rd_ptr;
    logic [wbffc_pkg::Q_CNT_W-1:0]    n_count;

    localparam logic [wbffc_pkg::Q_PTR_W-1:0] PTR_LAST =
        wbffc_pkg::Q_PTR_W'(wbffc_pkg::QUEUE_DEPTH - 1);
    localparam logic [wbffc_pkg::Q_CNT_W-1:0] CNT_FULL =
        wbffc_pkg::Q_CNT_W'(wbffc_pkg::QUEUE_DEPTH);

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `WBFFC_ASSERT_SAME(a_pop_not_empty, i_pop, r_count != '0, "pop from empty queue")
    `WBFFC_ASSERT_NEXT(a_fill_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count did not rise")
    `WBFFC_ASSERT_NEXT(a_fill_down, i_pop && !i_push, r_count == $past(r_count) - 1'b1, "count did not fall")

endmodule

### rtl/wbffc_back.sv
// Back stage: applies each queued frame to the counters and the beacon
// latch, and holds the result transfer. Depends on wbffc_pkg and the macros.
`include "wlan_bssid_frame_filter_counter_assert.svh"

module wbffc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wbffc_pkg::t_q_status                i_q_status,
    input  wbffc_pkg::t_item                    i_item,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_matched,
    output logic [wbffc_pkg::TYPE_W-1:0]        o_frame_class,
    output logic [wbffc_pkg::CNT_OUT_W-1:0]     o_mgmt_count,
    output logic [wbffc_pkg::CNT_OUT_W-1:0]     o_ctrl_count,
    output logic [wbffc_pkg::CNT_OUT_W-1:0]     o_data_count,
    output logic signed [wbffc_pkg::RSSI_W-1:0] o_rssi_latest,
    output logic [wbffc_pkg::TIME_W-1:0]        o_rssi_time_ms,
    output logic                                o_rssi_updated
);

    logic                                r_out_valid;
    logic                                n_out_valid;
    logic                                r_matched;
    wbffc_pkg::t_frame_class             r_class;
    logic                                r_updated;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   r_mgmt_total;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   r_ctrl_total;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   r_data_total;
    logic signed [wbffc_pkg::RSSI_W-1:0] r_beacon_rssi;
    logic [wbffc_pkg::TIME_W-1:0]        r_beacon_time;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   n_mgmt_total;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   n_ctrl_total;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   n_data_total;
    logic signed [wbffc_pkg::RSSI_W-1:0] n_beacon_rssi;
    logic [wbffc_pkg::TIME_W-1:0]        n_beacon_time;
    logic                                hit;
    logic                                latch;

    // A frame leaves the queue whenever the result register is free or its result is being taken.
    assign o_pop = !i_q_status.empty && (!r_out_valid || !i_out_stall);

    // Match rule per frame type.
    always_comb begin
        case (i_item.frame_class)
            wbffc_pkg::FC_MGMT: hit = i_item.mgmt_hit;
            wbffc_pkg::FC_CTRL: hit = i_item.any_hit;
            wbffc_pkg::FC_DATA: hit = i_item.any_hit;
            default:            hit = 1'b0;
        endcase
        latch = (i_item.frame_class == wbffc_pkg::FC_MGMT) && i_item.mgmt_hit
                && i_item.beacon_hit;
    end

    // Counter and beacon latch updates for the frame being popped.
    always_comb begin
        n_mgmt_total  = r_mgmt_total;
        n_ctrl_total  = r_ctrl_total;
        n_data_total  = r_data_total;
        n_beacon_rssi = r_beacon_rssi;
        n_beacon_time = r_beacon_time;
        if (o_pop && hit) begin
            case (i_item.frame_class)
                wbffc_pkg::FC_MGMT: n_mgmt_total = r_mgmt_total + wbffc_pkg::CNT_ONE;
                wbffc_pkg::FC_CTRL: n_ctrl_total = r_ctrl_total + wbffc_pkg::CNT_ONE;
                wbffc_pkg::FC_DATA: n_data_total = r_data_total + wbffc_pkg::CNT_ONE;
                default:            n_mgmt_total = r_mgmt_total;
            endcase
        end
        if (o_pop && latch) begin
            n_beacon_rssi = i_item.rssi;
            n_beacon_time = i_item.now_ms;
        end
    end

    // Result valid: set by a pop, cleared once the transfer completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_mgmt_total  <= '0;
            r_ctrl_total  <= '0;
            r_data_total  <= '0;
            r_beacon_rssi <= '0;
            r_beacon_time <= '0;
        end else begin
            r_out_valid   <= n_out_valid;
            r_mgmt_total  <= n_mgmt_total;
            r_ctrl_total  <= n_ctrl_total;
            r_data_total  <= n_data_total;
            r_beacon_rssi <= n_beacon_rssi;
            r_beacon_time <= n_beacon_time;
        end
    end

    // Per-frame result flags.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_matched <= hit;
            r_class   <= i_item.frame_class;
            r_updated <= latch;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_matched      = r_matched;
    assign o_frame_class  = r_class;
    assign o_rssi_updated = r_updated;
    assign o_mgmt_count   = wbffc_pkg::CNT_OUT_W'(r_mgmt_total);
    assign o_ctrl_count   = wbffc_pkg::CNT_OUT_W'(r_ctrl_total);
    assign o_data_count   = wbffc_pkg::CNT_OUT_W'(r_data_total);
    assign o_rssi_latest  = r_beacon_rssi;
    assign o_rssi_time_ms = r_beacon_time;

    `WBFFC_ASSERT_SAME(a_update_is_mgmt, r_out_valid && r_updated, r_matched && (r_class == wbffc_pkg::FC_MGMT), "beacon latch without a counted management frame")
    `WBFFC_ASSERT_SAME(a_mgmt_step, $past(i_rst_n) && (r_mgmt_total != $past(r_mgmt_total)), $past(o_pop && hit && (i_item.frame_class == wbffc_pkg::FC_MGMT)), "management counter moved without a match")
    `WBFFC_ASSERT_SAME(a_data_step, $past(i_rst_n) && (r_data_total != $past(r_data_total)), $past(o_pop && hit && (i_item.frame_class == wbffc_pkg::FC_DATA)), "data counter moved without a match")

endmodule

### tb/testbench.sv
// Self-checking testbench for the BSSID frame filter and counter.
// Depends on wbffc_pkg and wlan_bssid_frame_filter_counter; it needs no other file.
`timescale 1ns / 1ps

module testbench;

    // Run control constants.
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam logic [wbffc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED =
        wbffc_pkg::CFG_IDX_W'(1);
    localparam logic [wbffc_pkg::ADDR_W-1:0] ALL_ONES_BSSID = '1;
    localparam logic [wbffc_pkg::ADDR_W-1:0] DIRECTED_BSSID = 48'h0A1B_2C3D_4E5F;
    localparam logic [wbffc_pkg::FC_W-1:0] PROBE_REQ_BYTE = 8'h40;

    // Expected contents of one result transfer.
    typedef struct {
        logic                                matched;
        wbffc_pkg::t_frame_class             frame_class;
        logic [wbffc_pkg::CNT_OUT_W-1:0]     mgmt_count;
        logic [wbffc_pkg::CNT_OUT_W-1:0]     ctrl_count;
        logic [wbffc_pkg::CNT_OUT_W-1:0]     data_count;
        logic signed [wbffc_pkg::RSSI_W-1:0] rssi_latest;
        logic [wbffc_pkg::TIME_W-1:0]        rssi_time_ms;
        logic                                rssi_updated;
    } t_frame_verdict;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [wbffc_pkg::CFG_ADDR_W-1:0]    paddr = '0;
    logic [wbffc_pkg::CFG_DATA_W-1:0]    pwdata = '0;
    logic [wbffc_pkg::CFG_DATA_W-1:0]    prdata;
    logic                                pready;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [wbffc_pkg::FC_W-1:0]          i_frame_ctrl_byte = '0;
    logic [wbffc_pkg::ADDR_W-1:0]        i_addr_one = '0;
    logic [wbffc_pkg::ADDR_W-1:0]        i_addr_two = '0;
    logic [wbffc_pkg::ADDR_W-1:0]        i_addr_three = '0;
    logic signed [wbffc_pkg::RSSI_W-1:0] i_rx_rssi = '0;
    logic [wbffc_pkg::TIME_W-1:0]        i_now_ms = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic                                o_matched;
    logic [wbffc_pkg::TYPE_W-1:0]        o_frame_class;
    logic [wbffc_pkg::CNT_OUT_W-1:0]     o_mgmt_count;
    logic [wbffc_pkg::CNT_OUT_W-1:0]     o_ctrl_count;
    logic [wbffc_pkg::CNT_OUT_W-1:0]     o_data_count;
    logic signed [wbffc_pkg::RSSI_W-1:0] o_rssi_latest;
    logic [wbffc_pkg::TIME_W-1:0]        o_rssi_time_ms;
    logic                                o_rssi_updated;

    // Predicted block state.
    logic [wbffc_pkg::ADDR_W-1:0]        watched_bssid = '0;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   mgmt_seen = '0;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   ctrl_seen = '0;
    logic [wbffc_pkg::COUNT_WIDTH-1:0]   data_seen = '0;
    logic signed [wbffc_pkg::RSSI_W-1:0] beacon_rssi_held = '0;
    logic [wbffc_pkg::TIME_W-1:0]        beacon_stamp_held = '0;

    t_frame_verdict pending_verdicts[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  tx_gaps_on = 1'b0;
    bit  rx_stall_on = 1'b0;
    int  hold_req_cnt = 0;
    int  hold_ack_cnt = 0;
    int  hold_left = 0;
    int  phase_left = 0;

    wlan_bssid_frame_filter_counter DUT (.*);

    // Clock generator, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the result of one frame and advances the predicted state.
    function automatic t_frame_verdict filter_frame(
        input logic [wbffc_pkg::FC_W-1:0]          fc,
        input logic [wbffc_pkg::ADDR_W-1:0]        a1,
        input logic [wbffc_pkg::ADDR_W-1:0]        a2,
        input logic [wbffc_pkg::ADDR_W-1:0]        a3,
        input logic signed [wbffc_pkg::RSSI_W-1:0] rssi,
        input logic [wbffc_pkg::TIME_W-1:0]        now
    );
        t_frame_verdict v;
        logic any_hit;
        v.frame_class  = wbffc_pkg::t_frame_class'(
            fc[wbffc_pkg::TYPE_LSB +: wbffc_pkg::TYPE_W]);
        any_hit        = (a1 == watched_bssid) || (a2 == watched_bssid) ||
                         (a3 == watched_bssid);
        v.matched      = 1'b0;
        v.rssi_updated = 1'b0;
        case (v.frame_class)
            wbffc_pkg::FC_MGMT: begin
                if (a3 == watched_bssid) begin
                    v.matched = 1'b1;
                    mgmt_seen = mgmt_seen + wbffc_pkg::CNT_ONE;
                    if (fc == wbffc_pkg::BEACON_BYTE && a2 == watched_bssid) begin
                        beacon_rssi_held  = rssi;
                        beacon_stamp_held = now;
                        v.rssi_updated    = 1'b1;
                    end
                end
            end
            wbffc_pkg::FC_CTRL: begin
                if (any_hit) begin
                    v.matched = 1'b1;
                    ctrl_seen = ctrl_seen + wbffc_pkg::CNT_ONE;
                end
            end
            wbffc_pkg::FC_DATA: begin
                if (any_hit) begin
                    v.matched = 1'b1;
                    data_seen = data_seen + wbffc_pkg::CNT_ONE;
                end
            end
            default: ;
        endcase
        v.mgmt_count   = wbffc_pkg::CNT_OUT_W'(mgmt_seen);
        v.ctrl_count   = wbffc_pkg::CNT_OUT_W'(ctrl_seen);
        v.data_count   = wbffc_pkg::CNT_OUT_W'(data_seen);
        v.rssi_latest  = beacon_rssi_held;
        v.rssi_time_ms = beacon_stamp_held;
        return v;
    endfunction

    // Reports one field mismatch.
    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_frame_verdict v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("result transfer with no frame outstanding");
                fail_count++;
            end else begin
                v = pending_verdicts.pop_front();
                check_field("matched", v.matched, o_matched);
                check_field("frame_class", v.frame_class, o_frame_class);
                check_field("mgmt_count", v.mgmt_count, o_mgmt_count);
                check_field("ctrl_count", v.ctrl_count, o_ctrl_count);
                check_field("data_count", v.data_count, o_data_count);
                check_field("rssi_latest", v.rssi_latest, o_rssi_latest);
                check_field("rssi_time_ms", v.rssi_time_ms, o_rssi_time_ms);
                check_field("rssi_updated", v.rssi_updated, o_rssi_updated);
            end
        end
    end

    // Receiver stall pattern: alternating free and stalled runs, plus long holds on request.
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!rx_stall_on) begin
            i_out_stall <= 1'b0;
        end else if (phase_left != 0) begin
            phase_left <= phase_left - 1;
        end else begin
            i_out_stall <= !i_out_stall;
            phase_left  <= i_out_stall ? $urandom_range(0, 12) : $urandom_range(0, 5);
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one frame, with a random gap between bursts, and records its prediction.
    task automatic send_frame(
        input logic [wbffc_pkg::FC_W-1:0]          fc,
        input logic [wbffc_pkg::ADDR_W-1:0]        a1,
        input logic [wbffc_pkg::ADDR_W-1:0]        a2,
        input logic [wbffc_pkg::ADDR_W-1:0]        a3,
        input logic signed [wbffc_pkg::RSSI_W-1:0] rssi,
        input logic [wbffc_pkg::TIME_W-1:0]        now
    );
        int gap;
        if (burst_left == 0) begin
            if (tx_gaps_on) begin
                gap = $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_in_valid        <= 1'b1;
        i_frame_ctrl_byte <= fc;
        i_addr_one        <= a1;
        i_addr_two        <= a2;
        i_addr_three      <= a3;
        i_rx_rssi         <= rssi;
        i_now_ms          <= now;
        do @(posedge i_clk); while (o_in_stall);
        pending_verdicts.push_back(filter_frame(fc, a1, a2, a3, rssi, now));
        burst_left--;
    endtask

    // Picks an address: the watched BSSID with the given odds, else a near miss or noise.
    function automatic logic [wbffc_pkg::ADDR_W-1:0] pick_addr(input int hit_pct);
        logic [wbffc_pkg::ADDR_W-1:0] a;
        if ($urandom_range(0, 99) < hit_pct) begin
            a = watched_bssid;
        end else begin
            case ($urandom_range(0, 3))
                0: a = watched_bssid ^ (wbffc_pkg::ADDR_W'(1)
                       << $urandom_range(0, wbffc_pkg::ADDR_W - 1));
                1: a = '0;
                2: a = ALL_ONES_BSSID;
                default: a = wbffc_pkg::ADDR_W'({$urandom(), $urandom()});
            endcase
        end
        return a;
    endfunction

    // Sends one random frame, biased toward frames that reach the target.
    task automatic send_random_frame();
        logic [wbffc_pkg::FC_W-1:0] fc;
        int a2_pct;
        int a3_pct;
        int pick;
        fc     = wbffc_pkg::FC_W'($urandom());
        a2_pct = 30;
        a3_pct = 40;
        pick   = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: begin
                fc     = wbffc_pkg::BEACON_BYTE;
                a2_pct = 70;
                a3_pct = 80;
            end
            3: fc[wbffc_pkg::TYPE_LSB +: wbffc_pkg::TYPE_W] = wbffc_pkg::FC_MGMT;
            4: fc[wbffc_pkg::TYPE_LSB +: wbffc_pkg::TYPE_W] = wbffc_pkg::FC_CTRL;
            5: fc[wbffc_pkg::TYPE_LSB +: wbffc_pkg::TYPE_W] = wbffc_pkg::FC_DATA;
            6: fc[wbffc_pkg::TYPE_LSB +: wbffc_pkg::TYPE_W] = wbffc_pkg::FC_RSVD;
            default: ;
        endcase
        send_frame(fc, pick_addr(30), pick_addr(a2_pct), pick_addr(a3_pct),
                   wbffc_pkg::RSSI_W'($urandom()), $urandom());
    endtask

    // Lets every outstanding result drain, then waits a further DRAIN_CYCLES.
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [wbffc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [wbffc_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == wbffc_pkg::REG_TARGET_BSSID)
            watched_bssid = value[wbffc_pkg::ADDR_W-1:0];
    endtask

    // One register read, compared with the expected value.
    task automatic expect_register(input logic [wbffc_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [wbffc_pkg::CFG_DATA_W-1:0] exp_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", exp_val, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Right after reset the watched BSSID is zero, so all-zero addresses match.
    task automatic test_reset_target();
        expect_register(wbffc_pkg::REG_TARGET_BSSID, '0);
        send_frame(wbffc_pkg::BEACON_BYTE, '0, '0, '0, 8'sd127, 32'hFFFF_FFFF);
        send_frame(wbffc_pkg::BEACON_BYTE, ALL_ONES_BSSID, ALL_ONES_BSSID,
                   ALL_ONES_BSSID, -8'sd1, 32'h1);
        send_frame(8'h08, ALL_ONES_BSSID, '0, ALL_ONES_BSSID, 8'sd0, 32'h0);
        wait_until_idle();
    endtask

    // Register write, read back, masking of the upper bits and an unmapped index.
    task automatic test_register_access();
        write_register(wbffc_pkg::REG_TARGET_BSSID, {16'hFFFF, DIRECTED_BSSID});
        expect_register(wbffc_pkg::REG_TARGET_BSSID,
                        wbffc_pkg::CFG_DATA_W'(DIRECTED_BSSID));
        write_register(REG_UNMAPPED, {$urandom(), $urandom()});
        expect_register(wbffc_pkg::REG_TARGET_BSSID,
                        wbffc_pkg::CFG_DATA_W'(DIRECTED_BSSID));
    endtask

    // Hand-picked frames: each frame type, beacon rules and field extremes.
    task automatic test_directed_frames();
        logic [wbffc_pkg::ADDR_W-1:0] t;
        logic [wbffc_pkg::ADDR_W-1:0] other;
        t     = DIRECTED_BSSID;
        other = ~DIRECTED_BSSID;
        // Beacon from the target latches RSSI and time.
        send_frame(wbffc_pkg::BEACON_BYTE, other, t, t, -8'sd128, 32'h0);
        // Beacon with a foreign transmitter counts but does not latch.
        send_frame(wbffc_pkg::BEACON_BYTE, t, other, t, 8'sd127, 32'hFFFF_FFFF);
        // Other management subtypes count without latching.
        send_frame(PROBE_REQ_BYTE, other, t, t, 8'sd5, 32'h1234_5678);
        send_frame(8'h81, other, t, t, 8'sd6, 32'h8765_4321);
        send_frame(8'h00, t, t, t, 8'sd127, 32'hFFFF_FFFF);
        // Management frame with a foreign BSSID field never counts.
        send_frame(8'h00, t, t, other, 8'sd1, 32'h1);
        send_frame(wbffc_pkg::BEACON_BYTE, other, t, other, -8'sd50, 32'h2);
        // Control and data frames count on any address.
        send_frame(8'hB4, t, other, other, -8'sd1, 32'h3);
        send_frame(8'hC4, other, t, other, -8'sd2, 32'h4);
        send_frame(8'hF4, other, other, t, -8'sd3, 32'h5);
        send_frame(8'hD4, other, other, other, -8'sd4, 32'h6);
        send_frame(8'h08, other, other, t, 8'sd10, 32'h7);
        send_frame(8'h88, t, other, other, 8'sd11, 32'h8);
        send_frame(8'h48, other, other, other, 8'sd12, 32'h9);
        // Reserved type changes nothing even with every address matching.
        send_frame(8'h0C, t, t, t, 8'sd20, 32'hA);
        send_frame(8'hFF, t, t, t, -8'sd128, 32'hFFFF_FFFF);
        wait_until_idle();
        // All-ones target.
        write_register(wbffc_pkg::REG_TARGET_BSSID,
                       wbffc_pkg::CFG_DATA_W'(ALL_ONES_BSSID));
        send_frame(wbffc_pkg::BEACON_BYTE, '0, ALL_ONES_BSSID, ALL_ONES_BSSID,
                   8'sd127, 32'hFFFF_FFFF);
        send_frame(8'h08, '0, ALL_ONES_BSSID, '0, -8'sd128, 32'h0);
        send_frame(8'h04, ALL_ONES_BSSID, '0, '0, 8'sd0, 32'h0);
        wait_until_idle();
    endtask

    // Random frames in phases with different targets and idling patterns.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_register(wbffc_pkg::REG_TARGET_BSSID, '0);
                1: write_register(wbffc_pkg::REG_TARGET_BSSID,
                                  wbffc_pkg::CFG_DATA_W'(ALL_ONES_BSSID));
                default: write_register(wbffc_pkg::REG_TARGET_BSSID,
                                        {$urandom(), $urandom()});
            endcase
            tx_gaps_on = (phase != 1);
            rx_stall_on <= (phase != 1);
            repeat (420) send_random_frame();
            wait_until_idle();
        end
    endtask

    // The receiver holds off for a long stretch while frames keep coming.
    task automatic test_output_hold();
        tx_gaps_on = 1'b0;
        rx_stall_on <= 1'b0;
        write_register(wbffc_pkg::REG_TARGET_BSSID, {$urandom(), $urandom()});
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (48) send_random_frame();
        wait_until_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_target();
        test_register_access();
        test_directed_frames();
        test_random_traffic();
        test_output_hold();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### wlan_bssid_frame_filter_counter.f
+incdir+rtl
rtl/wbffc_pkg.sv
rtl/wbffc_front.sv
rtl/wbffc_queue.sv
rtl/wbffc_back.sv
rtl/wlan_bssid_frame_filter_counter.sv
tb/testbench.sv
